[hdl/btha_pkg.sv]
// ----------------------------------------------------------------------------
// btha_pkg
// Shared types and constants for the boundary-tag heap allocator: tag layout,
// request kinds, result codes and the controller-to-datapath command set.
// ----------------------------------------------------------------------------
`default_nettype none

package btha_pkg;

  // tag layout: size in bits [..:2], preceding-allocated flag, allocated flag
  localparam int ALLOC_POS = 0;
  localparam int PREC_POS  = 1;

  // bytes per heap word as a shift, and width of a rounded need in words
  localparam int WORD_SHIFT = 3;
  localparam int NEED_W     = 14;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result codes
  localparam logic [1:0] ST_ALLOC_OK  = 2'd0;
  localparam logic [1:0] ST_NO_FIT    = 2'd1;
  localparam logic [1:0] ST_FREED     = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

  // datapath operations
  localparam logic [4:0] OP_NONE   = 5'd0;
  localparam logic [4:0] OP_CLR    = 5'd1;
  localparam logic [4:0] OP_LOAD   = 5'd2;
  localparam logic [4:0] OP_A_INIT = 5'd3;
  localparam logic [4:0] OP_A_RD   = 5'd4;
  localparam logic [4:0] OP_A_NEXT = 5'd5;
  localparam logic [4:0] OP_A_TAKE = 5'd6;
  localparam logic [4:0] OP_A_WF   = 5'd7;
  localparam logic [4:0] OP_A_WR1  = 5'd8;
  localparam logic [4:0] OP_A_WR2  = 5'd9;
  localparam logic [4:0] OP_SP_RD  = 5'd10;
  localparam logic [4:0] OP_SP_W   = 5'd11;
  localparam logic [4:0] OP_SP_WF  = 5'd12;
  localparam logic [4:0] OP_F_RD   = 5'd13;
  localparam logic [4:0] OP_F_W1   = 5'd14;
  localparam logic [4:0] OP_F_W2   = 5'd15;
  localparam logic [4:0] OP_F_PRV  = 5'd16;
  localparam logic [4:0] OP_F_PEV  = 5'd17;
  localparam logic [4:0] OP_F_NX   = 5'd18;
  localparam logic [4:0] OP_F_NADV = 5'd19;
  localparam logic [4:0] OP_F_ST   = 5'd20;
  localparam logic [4:0] OP_F_W3   = 5'd21;
  localparam logic [4:0] OP_F_W4   = 5'd22;
  localparam logic [4:0] OP_RES    = 5'd23;
  localparam logic [4:0] OP_EMIT   = 5'd24;

  // command from controller to datapath
  typedef struct packed {
    logic [4:0] op;
    logic [1:0] code;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic clr_last;
    logic is_free;
    logic alloc_bad;
    logic fit;
    logic a_stop;
    logic rem_zero;
    logic sp_in;
    logic f_addr_bad;
    logic f_bad;
    logic prev_try;
    logic nx_go;
    logic nx_merge;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

[hdl/boundary_tag_heap_allocator.sv]
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// Next-fit boundary-tag allocator over a word-addressed tag store.
//
//   channel   dir  tdata                                   tuser
//   s_axis    in   [15:0] request_bytes, [27:16] free_addr  kind
//   m_axis    out  [11:0] granted_address                   status
//
// Allocate: the search reads one tag per block visited, through the single
// registered read port of the tag store.
// Free: each following free block is read and merged in turn.
// After reset a clearing pass writes every tag word with s_axis_tready low.
// A result word waits in the output register while the next request runs;
// it stalls only at hand-off if the earlier word is still not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module boundary_tag_heap_allocator import btha_pkg::*; #(
  parameter int HEAP_WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // request_bytes, free_address
  input  wire logic        s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // granted_address
  output logic [1:0]       m_axis_tuser    // status
);

  cmd_t        cmd;
  stat_t       stat;
  logic [11:0] out_addr;

  btha_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  btha_dpath #(
    .HEAP_WORDS (HEAP_WORDS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_kind    (s_axis_tuser),
    .in_bytes   (s_axis_tdata[15:0]),
    .in_addr    (s_axis_tdata[27:16]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_addr   (out_addr),
    .out_status (m_axis_tuser)
  );

  assign m_axis_tdata = {4'b0000, out_addr};

endmodule

`default_nettype wire

[hdl/btha_dpath.sv]
// ----------------------------------------------------------------------------
// btha_dpath
// Tag store, block pointers and result register. Carries out one command
// per cycle; the tag store has one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module btha_dpath import btha_pkg::*; #(
  parameter int HEAP_WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire logic        in_kind,
  input  wire logic [15:0] in_bytes,
  input  wire logic [11:0] in_addr,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      out_addr,
  output logic [1:0]       out_status
);

  localparam int SW = $clog2(HEAP_WORDS + 1);
  localparam int AW = $clog2(HEAP_WORDS);
  localparam int TW = SW + 2;
  localparam int CW = ((SW > NEED_W) ? SW : NEED_W) + 1;
  localparam logic [CW-1:0] HEAP_C = CW'(HEAP_WORDS);
  localparam logic [AW-1:0] LAST_A = AW'(HEAP_WORDS - 1);

  // tag store
  logic [TW-1:0] tag_mem [HEAP_WORDS];
  logic [TW-1:0] rdata;
  logic          we;
  logic [CW-1:0] waddr, raddr;
  logic [TW-1:0] wdata;

  // request and walk registers
  logic          kind;
  logic [15:0]   bytes;
  logic [11:0]   addr;
  logic [CW-1:0] p, q, s, sz, e, start;
  logic [SW-1:0] iter;
  logic [TW-1:0] t, t2;
  logic          pon;
  logic [AW-1:0] rover, cnt;
  logic [1:0]    pend_status;
  logic [11:0]   pend_addr;

  // derived values
  logic [16:0]   bsum;
  logic [CW-1:0] need, h, rsize, p_sum, p_next, rover_c, a_rov, rem, t2_size, sp_f;
  logic          ralloc;
  logic [TW-1:0] htag, ftag, sp_tag, mtag, init_tag;

  always_comb begin
    bsum     = {1'b0, bytes} + 17'd7;
    need     = CW'(bsum[16:WORD_SHIFT]) + CW'(2);
    h        = CW'(addr) - CW'(1);
    rsize    = CW'(rdata[TW-1:2]);
    ralloc   = rdata[ALLOC_POS];
    p_sum    = p + ((rsize != '0) ? rsize : CW'(1));
    p_next   = (p_sum >= HEAP_C) ? '0 : p_sum;
    rover_c  = CW'(rover);
    a_rov    = ((p + need) >= HEAP_C) ? '0 : (p + need);
    rem      = sz - need;
    htag     = {need[SW-1:0], t[PREC_POS], 1'b1};
    ftag     = {rem[SW-1:0], 2'b10};
    sp_tag   = pon ? (rdata | TW'(2)) : (rdata & ~TW'(2));
    t2_size  = CW'(t2[TW-1:2]);
    sp_f     = q + t2_size - CW'(1);
    mtag     = {SW'(e - start), rdata[PREC_POS], 1'b0};
    init_tag = {SW'(HEAP_WORDS), 2'b00};
  end

  // status back to the controller
  always_comb begin
    stat.clr_last   = (cnt == LAST_A);
    stat.is_free    = (kind == KIND_FREE);
    stat.alloc_bad  = (bytes == '0) || (need > HEAP_C);
    stat.fit        = !ralloc && (rsize >= need) && ((p + rsize) <= HEAP_C);
    stat.a_stop     = (p_next == rover_c) || ((CW'(iter) + CW'(1)) == HEAP_C);
    stat.rem_zero   = (sz == need);
    stat.sp_in      = (q < HEAP_C);
    stat.f_addr_bad = (addr == '0) || (CW'(addr) >= (HEAP_C - CW'(1)));
    stat.f_bad      = !ralloc || (rsize < CW'(2)) || ((h + rsize) > HEAP_C);
    stat.prev_try   = !t[PREC_POS] && (h != '0);
    stat.nx_go      = (CW'(iter) < HEAP_C) && (e < HEAP_C);
    stat.nx_merge   = !ralloc && (rsize != '0) && ((e + rsize) <= HEAP_C);
    stat.out_busy   = out_valid && !out_ready;
  end

  // store port selection
  always_comb begin
    we    = 1'b0;
    waddr = p;
    wdata = t;
    raddr = p;
    unique case (cmd.op)
      OP_CLR: begin
        we    = 1'b1;
        waddr = CW'(cnt);
        wdata = ((cnt == '0) || (cnt == LAST_A)) ? init_tag : '0;
      end
      OP_A_RD:  raddr = p;
      OP_A_TAKE: begin
        we    = 1'b1;
        waddr = p;
        wdata = {need[SW-1:0], rdata[PREC_POS], 1'b1};
      end
      OP_A_WF: begin
        we    = 1'b1;
        waddr = p + need - CW'(1);
        wdata = htag;
      end
      OP_A_WR1: begin
        we    = 1'b1;
        waddr = p + need;
        wdata = ftag;
      end
      OP_A_WR2: begin
        we    = 1'b1;
        waddr = p + sz - CW'(1);
        wdata = ftag;
      end
      OP_SP_RD: raddr = q;
      OP_SP_W: begin
        we    = 1'b1;
        waddr = q;
        wdata = sp_tag;
      end
      OP_SP_WF: begin
        we    = (t2_size != '0) && (sp_f < HEAP_C);
        waddr = sp_f;
        wdata = t2;
      end
      OP_F_RD:  raddr = h;
      OP_F_W1: begin
        we    = 1'b1;
        waddr = h;
        wdata = rdata & ~TW'(1);
      end
      OP_F_W2: begin
        we    = 1'b1;
        waddr = h + s - CW'(1);
        wdata = t;
      end
      OP_F_PRV: raddr = h - CW'(1);
      OP_F_NX:  raddr = e;
      OP_F_ST:  raddr = start;
      OP_F_W3: begin
        we    = 1'b1;
        waddr = start;
        wdata = mtag;
      end
      OP_F_W4: begin
        we    = 1'b1;
        waddr = e - CW'(1);
        wdata = t;
      end
      default: ;
    endcase
  end

  // tag store: one write, one registered read
  always_ff @(posedge clk) begin
    if (we) begin
      tag_mem[waddr[AW-1:0]] <= wdata;
    end
    rdata <= tag_mem[raddr[AW-1:0]];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      rover     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.op == OP_CLR) begin
        cnt <= cnt + AW'(1);
      end
      if (cmd.op == OP_RES && cmd.code == ST_ALLOC_OK) begin
        rover <= a_rov[AW-1:0];
      end
      if (cmd.op == OP_F_W4 && rover_c > start && rover_c < e) begin
        rover <= start[AW-1:0];
      end
      if (cmd.op == OP_EMIT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // walk and result registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        kind  <= in_kind;
        bytes <= in_bytes;
        addr  <= in_addr;
      end
      OP_A_INIT: begin
        p    <= rover_c;
        iter <= '0;
      end
      OP_A_NEXT: begin
        p    <= p_next;
        iter <= iter + SW'(1);
      end
      OP_A_TAKE: begin
        t  <= rdata;
        sz <= rsize;
      end
      OP_A_WF: begin
        q   <= p + sz;
        pon <= 1'b1;
      end
      OP_SP_W: t2 <= sp_tag;
      OP_F_W1: begin
        t <= rdata & ~TW'(1);
        s <= rsize;
      end
      OP_F_W2: begin
        q   <= h + s;
        pon <= 1'b0;
      end
      OP_F_PRV: begin
        start <= h;
        e     <= h + s;
        iter  <= '0;
      end
      OP_F_PEV: begin
        if ((rsize != '0) && (rsize <= h) && !ralloc) begin
          start <= h - rsize;
        end
      end
      OP_F_NADV: begin
        e    <= e + rsize;
        iter <= iter + SW'(1);
      end
      OP_F_W3: t <= mtag;
      OP_RES: begin
        pend_status <= cmd.code;
        pend_addr   <= (cmd.code == ST_ALLOC_OK) ? 12'(p + CW'(1)) : '0;
      end
      OP_EMIT: begin
        out_status <= pend_status;
        out_addr   <= pend_addr;
      end
      default: ;
    endcase
  end

  // the roving position always names a word of the store
  a_rover_range: assert property (@(posedge clk) disable iff (rst)
    rover_c < HEAP_C) else $error("rover outside store");

  // only a successful allocation reports a non-zero address
  a_zero_addr: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_EMIT && pend_status != ST_ALLOC_OK) |=> out_addr == '0)
    else $error("address on failed request");

  // a merged block always covers the block being freed
  a_merge_span: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_F_W4 |-> (start <= h) && (e > h))
    else $error("merge span does not cover freed block");

endmodule

`default_nettype wire

[hdl/btha_ctrl.sv]
// ----------------------------------------------------------------------------
// btha_ctrl
// Sequencer of the allocator: clearing pass, next-fit search and split,
// free with merging, and hand-off of each result word.
// ----------------------------------------------------------------------------
`default_nettype none

module btha_ctrl import btha_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_CHECK  = 5'd2;
  localparam logic [4:0] S_A_RD   = 5'd3;
  localparam logic [4:0] S_A_EV   = 5'd4;
  localparam logic [4:0] S_A_WF   = 5'd5;
  localparam logic [4:0] S_A_WR1  = 5'd6;
  localparam logic [4:0] S_A_WR2  = 5'd7;
  localparam logic [4:0] S_SP_RD  = 5'd8;
  localparam logic [4:0] S_SP_EV  = 5'd9;
  localparam logic [4:0] S_SP_WF  = 5'd10;
  localparam logic [4:0] S_F_RD   = 5'd11;
  localparam logic [4:0] S_F_EV   = 5'd12;
  localparam logic [4:0] S_F_W2   = 5'd13;
  localparam logic [4:0] S_F_PRV  = 5'd14;
  localparam logic [4:0] S_F_PEV  = 5'd15;
  localparam logic [4:0] S_F_NX   = 5'd16;
  localparam logic [4:0] S_F_NEV  = 5'd17;
  localparam logic [4:0] S_F_ST   = 5'd18;
  localparam logic [4:0] S_F_W3   = 5'd19;
  localparam logic [4:0] S_F_W4   = 5'd20;
  localparam logic [4:0] S_FIN    = 5'd21;
  localparam logic [4:0] S_OUT    = 5'd22;

  logic [4:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  // next state and command
  always_comb begin
    state_next = state;
    cmd.op     = OP_NONE;
    cmd.code   = ST_ALLOC_OK;
    unique case (state)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_LOAD;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.is_free) begin
          if (stat.alloc_bad) begin
            cmd.op     = OP_RES;
            cmd.code   = ST_NO_FIT;
            state_next = S_OUT;
          end else begin
            cmd.op     = OP_A_INIT;
            state_next = S_A_RD;
          end
        end else if (stat.f_addr_bad) begin
          cmd.op     = OP_RES;
          cmd.code   = ST_BAD_FREE;
          state_next = S_OUT;
        end else begin
          state_next = S_F_RD;
        end
      end
      S_A_RD: begin
        cmd.op     = OP_A_RD;
        state_next = S_A_EV;
      end
      S_A_EV: begin
        if (stat.fit) begin
          cmd.op     = OP_A_TAKE;
          state_next = S_A_WF;
        end else if (stat.a_stop) begin
          cmd.op     = OP_RES;
          cmd.code   = ST_NO_FIT;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_A_NEXT;
          state_next = S_A_RD;
        end
      end
      S_A_WF: begin
        cmd.op     = OP_A_WF;
        state_next = stat.rem_zero ? S_SP_RD : S_A_WR1;
      end
      S_A_WR1: begin
        cmd.op     = OP_A_WR1;
        state_next = S_A_WR2;
      end
      S_A_WR2: begin
        cmd.op     = OP_A_WR2;
        state_next = S_FIN;
      end
      // flag update of the following block, shared by a free and an exact-fit allocation
      S_SP_RD: begin
        if (stat.sp_in) begin
          cmd.op     = OP_SP_RD;
          state_next = S_SP_EV;
        end else begin
          state_next = stat.is_free ? S_F_PRV : S_FIN;
        end
      end
      S_SP_EV: begin
        cmd.op     = OP_SP_W;
        state_next = S_SP_WF;
      end
      S_SP_WF: begin
        cmd.op     = OP_SP_WF;
        state_next = stat.is_free ? S_F_PRV : S_FIN;
      end
      S_F_RD: begin
        cmd.op     = OP_F_RD;
        state_next = S_F_EV;
      end
      S_F_EV: begin
        if (stat.f_bad) begin
          cmd.op     = OP_RES;
          cmd.code   = ST_BAD_FREE;
          state_next = S_OUT;
        end else begin
          cmd.op     = OP_F_W1;
          state_next = S_F_W2;
        end
      end
      S_F_W2: begin
        cmd.op     = OP_F_W2;
        state_next = S_SP_RD;
      end
      S_F_PRV: begin
        cmd.op     = OP_F_PRV;
        state_next = stat.prev_try ? S_F_PEV : S_F_NX;
      end
      S_F_PEV: begin
        cmd.op     = OP_F_PEV;
        state_next = S_F_NX;
      end
      S_F_NX: begin
        if (stat.nx_go) begin
          cmd.op     = OP_F_NX;
          state_next = S_F_NEV;
        end else begin
          state_next = S_F_ST;
        end
      end
      S_F_NEV: begin
        if (stat.nx_merge) begin
          cmd.op     = OP_F_NADV;
          state_next = S_F_NX;
        end else begin
          state_next = S_F_ST;
        end
      end
      S_F_ST: begin
        cmd.op     = OP_F_ST;
        state_next = S_F_W3;
      end
      S_F_W3: begin
        cmd.op     = OP_F_W3;
        state_next = S_F_W4;
      end
      S_F_W4: begin
        cmd.op     = OP_F_W4;
        state_next = S_FIN;
      end
      S_FIN: begin
        cmd.op     = OP_RES;
        cmd.code   = stat.is_free ? ST_FREED : ST_ALLOC_OK;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          cmd.op     = OP_EMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

[sim/boundary_tag_heap_allocator_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_chk
// Watches both stream channels of the allocator. Every request word that is
// taken is run through a local model of the tag store and rover, and the
// answer is queued. Each result word is compared with the oldest answer.
// ----------------------------------------------------------------------------
`default_nettype none

module boundary_tag_heap_allocator_chk import btha_pkg::*; #(
  parameter int HEAP_WORDS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [15:0] m_axis_tdata,
  input  wire logic [1:0]  m_axis_tuser,
  output int               fail_count,
  output int               pending
);

  typedef struct packed {
    logic [11:0] addr;
    logic [1:0]  status;
  } grant_t;

  int unsigned heap_tags [HEAP_WORDS];
  int unsigned rover;
  grant_t      grants_due [$];

  assign pending = grants_due.size();

  function automatic int unsigned tag_of(int unsigned size, int unsigned flags);
    return (size << 2) | (flags & 3);
  endfunction

  task automatic heap_init();
    foreach (heap_tags[i]) heap_tags[i] = 0;
    heap_tags[0] = tag_of(HEAP_WORDS, 0);
    heap_tags[HEAP_WORDS-1] = heap_tags[0];
    rover = 0;
  endtask

  // set or clear the preceding-allocated flag of the block at pos
  task automatic mark_prec(int unsigned pos, bit on);
    int unsigned t;
    if (pos >= HEAP_WORDS) return;
    t = on ? (heap_tags[pos] | (1 << PREC_POS)) : (heap_tags[pos] & ~(1 << PREC_POS));
    heap_tags[pos] = t;
    if ((t >> 2) == 0) return;
    if (pos + (t >> 2) - 1 < HEAP_WORDS) heap_tags[pos + (t >> 2) - 1] = t;
  endtask

  task automatic heap_alloc(int unsigned bytes, output grant_t g);
    int unsigned need, p, t, sz, h, rem;
    g = '{addr: 0, status: ST_NO_FIT};
    if (bytes == 0) return;
    need = (bytes + 7) / 8 + 2;
    if (need > HEAP_WORDS) return;
    p = (rover >= HEAP_WORDS) ? 0 : rover;
    for (int i = 0; i < HEAP_WORDS; i++) begin
      t = heap_tags[p];
      sz = t >> 2;
      if (!t[ALLOC_POS] && sz >= need && p + sz <= HEAP_WORDS) begin
        h = tag_of(need, (t & (1 << PREC_POS)) | 1);
        rem = sz - need;
        heap_tags[p] = h;
        heap_tags[p + need - 1] = h;
        if (rem > 0) begin
          heap_tags[p + need] = tag_of(rem, 1 << PREC_POS);
          heap_tags[p + sz - 1] = tag_of(rem, 1 << PREC_POS);
        end else begin
          mark_prec(p + sz, 1);
        end
        rover = p + need;
        if (rover >= HEAP_WORDS) rover = 0;
        g = '{addr: 12'(p + 1), status: ST_ALLOC_OK};
        return;
      end
      p += (sz != 0) ? sz : 1;
      if (p >= HEAP_WORDS) p = 0;
      if (p == rover) break;
    end
  endtask

  task automatic heap_free(int unsigned addr, output grant_t g);
    int unsigned h, t, s, start, e, nt, ns, ps, m;
    g = '{addr: 0, status: ST_BAD_FREE};
    if (addr == 0 || addr >= HEAP_WORDS - 1) return;
    h = addr - 1;
    t = heap_tags[h];
    s = t >> 2;
    if (!t[ALLOC_POS] || s < 2 || h + s > HEAP_WORDS) return;
    t &= ~(1 << ALLOC_POS);
    heap_tags[h] = t;
    heap_tags[h + s - 1] = t;
    mark_prec(h + s, 0);
    // coalesce backwards
    start = h;
    if (!t[PREC_POS] && h != 0) begin
      ps = heap_tags[h-1] >> 2;
      if (ps > 0 && ps <= h && !heap_tags[h-1][ALLOC_POS]) start = h - ps;
    end
    // coalesce forwards over the run of free blocks that follows
    e = h + s;
    for (int i = 0; i < HEAP_WORDS && e < HEAP_WORDS; i++) begin
      nt = heap_tags[e];
      ns = nt >> 2;
      if (nt[ALLOC_POS] || ns == 0 || e + ns > HEAP_WORDS) break;
      e += ns;
    end
    m = e - start;
    heap_tags[start] = tag_of(m, heap_tags[start] & (1 << PREC_POS));
    heap_tags[e-1] = heap_tags[start];
    if (rover > start && rover < e) rover = start;
    g.status = ST_FREED;
  endtask

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    heap_init();
  end

  // request side: predict
  always @(posedge clk) begin
    grant_t g;
    if (!rst && s_axis_tvalid && s_axis_tready) begin
      if (s_axis_tuser == KIND_ALLOC) heap_alloc(s_axis_tdata[15:0], g);
      else heap_free(s_axis_tdata[27:16], g);
      grants_due.push_back(g);
    end
  end

  // result side: compare
  always @(posedge clk) begin
    grant_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (grants_due.size() == 0) begin
        $display("%0t unexpected result word", $realtime);
        fail_count++;
      end else begin
        w = grants_due.pop_front();
        if (m_axis_tuser != w.status) report("status", m_axis_tuser, w.status);
        if (m_axis_tdata != {4'd0, w.addr}) report("address", m_axis_tdata, w.addr);
      end
    end
  end

endmodule

`default_nettype wire

[sim/boundary_tag_heap_allocator_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_tb
// Drives directed and random allocate/free request words with random gaps
// and result back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module boundary_tag_heap_allocator_tb import btha_pkg::*;;

  localparam int HW = 4096;
  localparam int WATCH_LIMIT = 40000;

  logic        clk = 0;
  logic        rst = 1;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = 0;
  logic        s_axis_tuser = 0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  int          fail_count, pending;
  int          idle_cycles;
  logic [11:0] live [$];

  always #5 clk = ~clk;

  boundary_tag_heap_allocator #(.HEAP_WORDS(HW)) dut (.*);
  boundary_tag_heap_allocator_chk #(.HEAP_WORDS(HW)) chk (.*);

  // keep granted addresses so frees mostly hit live blocks
  always @(posedge clk)
    if (!rst && m_axis_tvalid && m_axis_tready && m_axis_tuser == ST_ALLOC_OK)
      live.push_back(m_axis_tdata[11:0]);

  // result side stalls
  initial begin
    int w;
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      repeat (w) @(posedge clk);
      m_axis_tready <= 1;
      @(posedge clk);
      while (!m_axis_tvalid) @(posedge clk);
      m_axis_tready <= 0;
    end
  end

  // watchdog on cycles with no word moved
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCH_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send(logic kind, logic [15:0] bytes, logic [11:0] addr, bit gap);
    if (gap) repeat ($urandom_range(0, 14)) @(posedge clk);
    s_axis_tvalid <= 1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {4'd0, addr, bytes};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    s_axis_tvalid <= 0;
  endtask

  // let the checker see the last accepted word before polling its queue
  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  initial begin
    int r, idx;
    logic [11:0] a;
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: size extremes, bad sizes, bad frees, exact fit, double free
    send(KIND_ALLOC, 16'd0, 12'hfff, 1);
    send(KIND_ALLOC, 16'hffff, 12'd0, 1);
    send(KIND_ALLOC, 16'd32753, 12'd0, 1);  // need just over the store
    send(KIND_ALLOC, 16'd1, 12'd0, 1);
    send(KIND_ALLOC, 16'd8, 12'd0, 1);
    send(KIND_ALLOC, 16'd9, 12'd0, 1);
    send(KIND_FREE, 16'hffff, 12'd0, 1);
    send(KIND_FREE, 16'd0, 12'hfff, 1);
    send(KIND_FREE, 16'd0, 12'hffe, 1);
    send(KIND_FREE, 16'd0, 12'd5, 1);       // not a header
    send(KIND_FREE, 16'd0, 12'd4, 1);       // middle block
    send(KIND_FREE, 16'd0, 12'd4, 1);       // double free
    send(KIND_FREE, 16'd0, 12'd1, 1);       // merge forward
    send(KIND_FREE, 16'd0, 12'd7, 1);       // rover inside merge
    drain();
    send(KIND_ALLOC, 16'd32752, 12'd0, 0);  // whole store, exact fit
    send(KIND_ALLOC, 16'd1, 12'd0, 0);      // no fit
    send(KIND_FREE, 16'd0, 12'd1, 0);
    send(KIND_ALLOC, 16'd16000, 12'd0, 0);
    send(KIND_ALLOC, 16'd16352, 12'd0, 0);  // fits the rest with a remainder left
    send(KIND_FREE, 16'd0, 12'd2003, 0);
    send(KIND_FREE, 16'd0, 12'd1, 0);
    drain();
    live.delete();
    // random: mostly well-formed alloc/free traffic
    for (int i = 0; i < 500; i++) begin
      if (i == 250) drain();
      r = $urandom_range(0, 99);
      if (r < 45) begin
        send(KIND_ALLOC, ($urandom_range(0, 9) == 0) ? 16'($urandom) :
             16'($urandom_range(1, 400)), 12'($urandom), 1);
      end else if (r < 90 && live.size() > 0) begin
        idx = $urandom_range(0, live.size() - 1);
        a = live[idx];
        live.delete(idx);
        send(KIND_FREE, 16'($urandom), a, 1);
      end else begin
        send(KIND_FREE, 16'($urandom), 12'($urandom), 1);
      end
    end
    drain();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hdl/btha_pkg.sv
hdl/btha_dpath.sv
hdl/btha_ctrl.sv
hdl/boundary_tag_heap_allocator.sv
sim/boundary_tag_heap_allocator_chk.sv
sim/boundary_tag_heap_allocator_tb.sv
